// File: rtl/pbfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parity bit frame packer package
// Word types, the job record passed from front to back, and fixed constants.
// ----------------------------------------------------------------------------
package pbfp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 4;

    // Bits added by a full data byte with its parity bit.
    localparam logic [COUNT_W-1:0] ITEM_BITS = 4'd9;
    // Bits in one whole output byte.
    localparam logic [COUNT_W-1:0] FULL_BITS = 4'd8;

    typedef struct packed {
        logic [BYTE_W-1:0]  tx_byte;
        logic               parity_bit;
        logic               final_item;
        logic [COUNT_W-1:0] final_bits;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  frame_byte;
        logic [COUNT_W-1:0] frame_bits;
        logic               run_last;
        logic               frame_end;
    } word_t;

    // One classified input word: one or two output bytes ready to send.
    typedef struct packed {
        logic [BYTE_W-1:0]  byte0;
        logic [COUNT_W-1:0] bits0;
        logic [BYTE_W-1:0]  byte1;
        logic [COUNT_W-1:0] bits1;
        logic               two;
        logic               fend;
    } job_t;

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } back_phase_t;

endpackage

// File: rtl/pbfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parity bit frame packer front end
// Accepts input words, appends them to the bit carry and forms output jobs.
// ----------------------------------------------------------------------------
module pbfp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  pbfp_pkg::item_t item_data,
    input  logic            push_ready,
    output logic            push_valid,
    output pbfp_pkg::job_t  push_job
);

    logic [6:0] carry_bits_reg;
    logic [6:0] carry_bits_next;
    logic [2:0] carry_count_reg;
    logic [2:0] carry_count_next;
    logic       at_start_reg;
    logic       at_start_next;

    logic [3:0]  nb_eff;
    logic        single;
    logic        full;
    logic [8:0]  ins;
    logic [3:0]  ins_len;
    logic [15:0] acc;
    logic [4:0]  total;
    logic [3:0]  total_hi;
    logic [7:0]  part_mask;

    assign item_ready = push_ready;
    assign push_valid = item_valid;

    always_comb
    begin
        // Counts of zero or above eight mean a whole byte.
        if ((item_data.final_bits == 4'd0) || (item_data.final_bits > pbfp_pkg::FULL_BITS))
            nb_eff = pbfp_pkg::FULL_BITS;
        else
            nb_eff = item_data.final_bits;

        single    = item_data.final_item & at_start_reg;
        full      = !item_data.final_item || (nb_eff == pbfp_pkg::FULL_BITS);
        part_mask = 8'((9'd1 << nb_eff) - 9'd1);

        if (full)
        begin
            ins     = {item_data.parity_bit, item_data.tx_byte};
            ins_len = pbfp_pkg::ITEM_BITS;
        end
        else
        begin
            ins     = {1'b0, item_data.tx_byte & part_mask};
            ins_len = nb_eff;
        end

        acc      = {9'd0, carry_bits_reg} | ({7'd0, ins} << carry_count_reg);
        total    = 5'(carry_count_reg) + 5'(ins_len);
        total_hi = 4'(total - 5'd8);

        push_job       = '0;
        push_job.byte0 = acc[7:0];
        push_job.bits0 = pbfp_pkg::FULL_BITS;
        push_job.byte1 = acc[15:8];
        push_job.bits1 = pbfp_pkg::FULL_BITS;

        carry_bits_next  = 7'd0;
        carry_count_next = 3'd0;
        at_start_next    = 1'b1;

        if (single)
        begin
            push_job.byte0 = item_data.tx_byte;
            push_job.bits0 = nb_eff;
            push_job.fend  = 1'b1;
        end
        else if (!item_data.final_item)
        begin
            at_start_next = 1'b0;
            if (total == 5'd16)
                push_job.two = 1'b1;
            else
            begin
                carry_bits_next  = acc[14:8];
                carry_count_next = 3'(total_hi);
            end
        end
        else
        begin
            push_job.fend = 1'b1;
            if (total > 5'd8)
            begin
                push_job.two   = 1'b1;
                push_job.bits1 = total_hi;
            end
            else
                push_job.bits0 = 4'(total);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_bits_reg  <= 7'd0;
            carry_count_reg <= 3'd0;
            at_start_reg    <= 1'b1;
        end
        else if (item_valid && push_ready)
        begin
            carry_bits_reg  <= carry_bits_next;
            carry_count_reg <= carry_count_next;
            at_start_reg    <= at_start_next;
        end
    end

endmodule

// File: rtl/pbfp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parity bit frame packer job queue
// Small register FIFO that decouples the front end from the output stage.
// ----------------------------------------------------------------------------
module pbfp_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  pbfp_pkg::job_t push_job,
    output logic           head_valid,
    input  logic           pop,
    output pbfp_pkg::job_t head_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pbfp_pkg::job_t    slot_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg < CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop & head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: rtl/pbfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parity bit frame packer back end
// Sends each job as one or two output words through a registered output.
// ----------------------------------------------------------------------------
module pbfp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    input  pbfp_pkg::job_t  job,
    output logic            pop,
    output logic            word_valid,
    input  logic            word_ready,
    output pbfp_pkg::word_t word_data
);

    pbfp_pkg::back_phase_t phase_reg;
    pbfp_pkg::back_phase_t phase_next;
    logic                  word_valid_reg;
    pbfp_pkg::word_t       word_data_reg;
    pbfp_pkg::word_t       word_next;
    logic                  emit;

    // The output register may be reloaded when empty or being drained.
    assign emit       = job_valid && (!word_valid_reg || word_ready);
    assign word_valid = word_valid_reg;
    assign word_data  = word_data_reg;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            pbfp_pkg::PH_FIRST:
                if (emit && job.two)
                    phase_next = pbfp_pkg::PH_SECOND;
            pbfp_pkg::PH_SECOND:
                if (emit)
                    phase_next = pbfp_pkg::PH_FIRST;
            default:
                phase_next = pbfp_pkg::PH_FIRST;
        endcase
    end

    always_comb
    begin
        word_next = '0;
        pop       = 1'b0;
        unique case (phase_reg)
            pbfp_pkg::PH_FIRST:
            begin
                word_next.frame_byte = job.byte0;
                word_next.frame_bits = job.bits0;
                word_next.run_last   = !job.two;
                word_next.frame_end  = job.fend & !job.two;
                pop                  = emit & !job.two;
            end
            pbfp_pkg::PH_SECOND:
            begin
                word_next.frame_byte = job.byte1;
                word_next.frame_bits = job.bits1;
                word_next.run_last   = 1'b1;
                word_next.frame_end  = job.fend;
                pop                  = emit;
            end
            default:
            begin
                word_next = '0;
                pop       = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= pbfp_pkg::PH_FIRST;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (emit)
                word_valid_reg <= 1'b1;
            else if (word_ready)
                word_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            word_data_reg <= word_next;
    end

endmodule

// File: rtl/parity_bit_frame_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parity bit frame packer
// Packs data bytes and their parity bits into an LSB-first air bit stream.
// ----------------------------------------------------------------------------
// Each accepted input word is a data byte with its parity bit; the block
// appends the eight data bits and then the parity bit to a running bit
// stream and re-cuts it into output bytes, first air bit in bit 0. A final
// input word with fewer than eight valid bits adds only those bits, a full
// final byte keeps its parity, and any leftover bits are flushed with their
// count and frame_end set. A frame of one single word is passed through
// unchanged, without parity. An input word yields one or two output words;
// the output port sends one word per cycle while word_ready is high, and a
// job with two output words stays at the queue head until both are sent;
// a long frame gives about nine output words per eight input words.
// The input side is accepted every cycle while the job queue has room, so
// a burst of QUEUE_DEPTH words is taken even while the output is stalled.
// ----------------------------------------------------------------------------
module parity_bit_frame_packer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  pbfp_pkg::item_t item_data,
    output logic            word_valid,
    input  logic            word_ready,
    output pbfp_pkg::word_t word_data
);

    // Front end to queue.
    logic           push_valid;
    logic           push_ready;
    pbfp_pkg::job_t push_job;

    // Queue to back end.
    logic           head_valid;
    logic           pop;
    pbfp_pkg::job_t head_job;

    // The front end holds the bit carry and classifies each word as it is
    // accepted, so the carry is always current for the next word.
    pbfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    pbfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .head_valid (head_valid),
        .pop        (pop),
        .head_job   (head_job)
    );

    // The back end walks through the one or two bytes of each job.
    pbfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (head_valid),
        .job        (head_job),
        .pop        (pop),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word_data  (word_data)
    );

endmodule

// File: rtl/pbfp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parity bit frame packer checker
// Port-level checks on the output word stream of the packer.
// ----------------------------------------------------------------------------
module pbfp_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            word_valid,
    input logic            word_ready,
    input pbfp_pkg::word_t word_data
);

    // A stalled output word keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !word_ready |=> word_valid && $stable(word_data))
        else $error("output word changed while stalled");

    // The end of a frame is also the last word of its input word.
    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word_data.frame_end |-> word_data.run_last)
        else $error("frame end without run last");

    // Only the last word of a frame may be partial.
    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !word_data.frame_end |-> word_data.frame_bits == pbfp_pkg::FULL_BITS)
        else $error("partial word before frame end");

    // Every word carries between one and eight bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |-> (word_data.frame_bits != 4'd0)
                    && (word_data.frame_bits <= pbfp_pkg::FULL_BITS))
        else $error("bit count out of range");

endmodule

bind parity_bit_frame_packer pbfp_checker u_pbfp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word_data  (word_data)
);
